@@ rtl/tpfw_pkg.sv @@
// ----------------------------------------------------------------------------
// tpfw_pkg: shared types and constants of the text and pixel writer
// Request and response payloads, mode codes, character cell geometry and the
// 5x7 font ROM.
// ----------------------------------------------------------------------------
package tpfw_pkg;

  // Mode codes carried by a request
  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_CURSOR = 3'd1;
  localparam logic [2:0] MODE_CHAR   = 3'd2;
  localparam logic [2:0] MODE_PIXEL  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // Character cell geometry and printable range
  localparam int GLYPH_COLS = 5;
  localparam int CELL_COLS  = 6;
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd127;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] ch_code;
    logic [7:0] row;
    logic [7:0] col_char;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
  } tpfw_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] col_now;
    logic [3:0] page_now;
  } tpfw_rsp_t;

  // Font ROM: five columns per glyph, first column in the top byte
  function automatic logic [39:0] glyph_cols(input logic [6:0] idx);
    logic [39:0] g;
    unique case (idx)
      7'd0:  g = 40'h0000000000;  7'd1:  g = 40'h00005F0000;
      7'd2:  g = 40'h0007000700;  7'd3:  g = 40'h147F147F14;
      7'd4:  g = 40'h242A7F2A12;  7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;  7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001C224100;  7'd9:  g = 40'h0041221C00;
      7'd10: g = 40'h082A1C2A08;  7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000;  7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;  7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3E5149453E;  7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946;  7'd19: g = 40'h2141454B31;
      7'd20: g = 40'h1814127F10;  7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3C4A494930;  7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;  7'd25: g = 40'h064949291E;
      7'd26: g = 40'h0036360000;  7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0008142241;  7'd29: g = 40'h1414141414;
      7'd30: g = 40'h4122140800;  7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413E;  7'd33: g = 40'h7E1111117E;
      7'd34: g = 40'h7F49494936;  7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C;  7'd37: g = 40'h7F49494941;
      7'd38: g = 40'h7F09090101;  7'd39: g = 40'h3E41415132;
      7'd40: g = 40'h7F0808087F;  7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01;  7'd43: g = 40'h7F08142241;
      7'd44: g = 40'h7F40404040;  7'd45: g = 40'h7F0204027F;
      7'd46: g = 40'h7F0408107F;  7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906;  7'd49: g = 40'h3E4151215E;
      7'd50: g = 40'h7F09192946;  7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017F0101;  7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F;  7'd55: g = 40'h7F2018207F;
      7'd56: g = 40'h6314081463;  7'd57: g = 40'h0304780403;
      7'd58: g = 40'h6151494543;  7'd59: g = 40'h00007F4141;
      7'd60: g = 40'h0204081020;  7'd61: g = 40'h41417F0000;
      7'd62: g = 40'h0402010204;  7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;  7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438;  7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487F;  7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087E090102;  7'd71: g = 40'h081454543C;
      7'd72: g = 40'h7F08040478;  7'd73: g = 40'h00447D4000;
      7'd74: g = 40'h2040443D00;  7'd75: g = 40'h007F102844;
      7'd76: g = 40'h00417F4000;  7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478;  7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7C14141408;  7'd81: g = 40'h081414187C;
      7'd82: g = 40'h7C08040408;  7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020;  7'd85: g = 40'h3C4040207C;
      7'd86: g = 40'h1C2040201C;  7'd87: g = 40'h3C4030403C;
      7'd88: g = 40'h4428102844;  7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44;  7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007F0000;  7'd93: g = 40'h0041360800;
      7'd94: g = 40'h0804081008;  7'd95: g = 40'h0000000000;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/tpfw_store.sv @@
// ----------------------------------------------------------------------------
// tpfw_store: frame store memory
// Single-port byte memory with one write or read address per cycle and a
// registered read.
// ----------------------------------------------------------------------------
module tpfw_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/text_pixel_framebuffer_writer.sv @@
// ----------------------------------------------------------------------------
// text_pixel_framebuffer_writer: text and pixel writer for a paged frame store
// Keeps PAGE_COUNT pages of WIDTH_COLS bytes and a text cursor; draws 5x7
// characters, sets and clears pixels, reads bytes and clears the store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid/req_stall and each gives one response
//   on rsp/rsp_valid/rsp_stall. A transfer happens when valid is high and
//   stall is low. One request is worked on at a time; req_stall is high
//   while the sequencer is busy.
//   Steps per request: set cursor or unused mode goes straight to finish;
//     pixel write reads the byte, then writes it back; byte read reads,
//     then captures; draw character makes six column writes through the
//     single store port; clear sweeps the store, one byte cleared per cycle.
//   The response sits in an output register. A new request can be accepted
//   while it waits; a finished request holds in its last step until the
//   output register is free, so a stalled receiver only backs up the
//   sequencer and loses nothing.
//   After reset the store is cleared in a sweep over all PAGE_COUNT*WIDTH_COLS
//   bytes (1024 at the defaults) during which no request is accepted.
// ----------------------------------------------------------------------------
module text_pixel_framebuffer_writer #(
  parameter int WIDTH_COLS     = 128,
  parameter int PAGE_COUNT     = 8,
  parameter int TEXT_LINES     = 8,
  parameter int CHARS_PER_LINE = 21
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tpfw_pkg::tpfw_req_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tpfw_pkg::tpfw_rsp_t rsp
);

  import tpfw_pkg::*;

  localparam int DEPTH   = PAGE_COUNT * WIDTH_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int SET_MAX = (CHARS_PER_LINE - 1) * CELL_COLS;
  localparam int COL_MAX = (SET_MAX > WIDTH_COLS - 1) ? SET_MAX : WIDTH_COLS - 1;
  localparam int COL_W   = $clog2(COL_MAX + 1);
  localparam int PG_MAX  = (TEXT_LINES - 1 > PAGE_COUNT) ? TEXT_LINES - 1 : PAGE_COUNT;
  localparam int PG_W    = $clog2(PG_MAX + 1);

  typedef enum logic [7:0] {
    ST_SWEEP  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DRAW   = 8'b0000_0100,
    ST_PIX_RD = 8'b0000_1000,
    ST_PIX_WR = 8'b0001_0000,
    ST_RD     = 8'b0010_0000,
    ST_RD_CAP = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t          state;
  logic [AW-1:0]   sweep_addr;
  logic            sweep_item;
  logic [2:0]      cnt;
  logic [39:0]     glyph;
  logic [7:0]      op_page;
  logic [8:0]      op_col;
  logic [2:0]      op_bit;
  logic            op_on;
  logic [7:0]      rd_byte;
  logic [COL_W-1:0] cursor_col;
  logic [PG_W-1:0]  cursor_page;

  logic            accept;
  logic            rsp_free;
  logic [7:0]      a_page;
  logic [8:0]      a_col;
  logic [16:0]     addr_full;
  logic            st_we;
  logic [AW-1:0]   st_addr;
  logic [7:0]      st_wdata;
  logic [7:0]      st_rdata;
  logic [7:0]      glyph_byte;
  logic [7:0]      pix_mask;
  logic [8:0]      col_adv;
  logic            page_past;
  logic [7:0]      row_cl;
  logic [7:0]      colc_cl;
  logic [10:0]     col_set;
  logic [6:0]      code_idx;
  logic [15:0]     col_wide;
  logic [15:0]     page_wide;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Shared address unit: page times width plus column
  always_comb begin
    if (state == ST_DRAW) begin
      a_page = 8'(cursor_page);
      a_col  = 9'(cursor_col) + 9'(cnt);
    end else begin
      a_page = op_page;
      a_col  = op_col;
    end
    addr_full = 17'(a_page) * 17'(WIDTH_COLS) + 17'(a_col);
  end

  // Pick the glyph column for the current draw step; the spacer is blank
  always_comb begin
    unique case (cnt)
      3'd0:    glyph_byte = glyph[39:32];
      3'd1:    glyph_byte = glyph[31:24];
      3'd2:    glyph_byte = glyph[23:16];
      3'd3:    glyph_byte = glyph[15:8];
      3'd4:    glyph_byte = glyph[7:0];
      default: glyph_byte = 8'h00;
    endcase
  end

  assign pix_mask = 8'd1 << op_bit;

  // Store port control
  always_comb begin
    st_we    = 1'b0;
    st_addr  = addr_full[AW-1:0];
    st_wdata = 8'h00;
    unique case (state)
      ST_SWEEP: begin
        st_we   = 1'b1;
        st_addr = sweep_addr;
      end
      ST_DRAW: begin
        st_we    = (a_col < 9'(WIDTH_COLS));
        st_wdata = glyph_byte;
      end
      ST_PIX_WR: begin
        st_we    = 1'b1;
        st_wdata = op_on ? (st_rdata | pix_mask) : (st_rdata & ~pix_mask);
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  tpfw_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // Request decode helpers
  assign row_cl   = (req.row >= 8'(TEXT_LINES)) ? 8'(TEXT_LINES - 1) : req.row;
  assign colc_cl  = (req.col_char >= 8'(CHARS_PER_LINE)) ? 8'(CHARS_PER_LINE - 1)
                                                           : req.col_char;
  assign col_set  = 11'(colc_cl) * 11'(CELL_COLS);
  assign code_idx = (req.ch_code < FIRST_CODE || req.ch_code > LAST_CODE)
                    ? 7'd0 : 7'(req.ch_code - FIRST_CODE);
  assign col_adv  = 9'(cursor_col) + 9'(CELL_COLS);
  assign page_past = (5'(cursor_page) >= 5'(PAGE_COUNT));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_item  <= 1'b0;
      cnt         <= '0;
      cursor_col  <= '0;
      cursor_page <= '0;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          if (sweep_addr == AW'(DEPTH - 1)) begin
            sweep_addr <= '0;
            state      <= sweep_item ? ST_FINISH : ST_IDLE;
            sweep_item <= 1'b0;
          end else begin
            sweep_addr <= sweep_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_byte <= 8'h00;
            cnt     <= '0;
            unique case (req.mode)
              MODE_CLEAR: begin
                cursor_col  <= '0;
                cursor_page <= '0;
                sweep_item  <= 1'b1;
                state       <= ST_SWEEP;
              end
              MODE_CURSOR: begin
                cursor_page <= PG_W'(row_cl);
                cursor_col  <= COL_W'(col_set);
                state       <= ST_FINISH;
              end
              MODE_CHAR: begin
                glyph <= glyph_cols(code_idx);
                state <= page_past ? ST_FINISH : ST_DRAW;
              end
              MODE_PIXEL: begin
                op_page <= {3'd0, req.pixel_y[7:3]};
                op_col  <= 9'(req.pixel_x);
                op_bit  <= req.pixel_y[2:0];
                op_on   <= req.pixel_on;
                if (9'(req.pixel_x) < 9'(WIDTH_COLS) &&
                    9'(req.pixel_y) < 9'(8 * PAGE_COUNT)) begin
                  state <= ST_PIX_RD;
                end else begin
                  state <= ST_FINISH;
                end
              end
              MODE_READ: begin
                op_page <= req.row;
                op_col  <= 9'(req.pixel_x);
                if (9'(req.row) < 9'(PAGE_COUNT) &&
                    9'(req.pixel_x) < 9'(WIDTH_COLS)) begin
                  state <= ST_RD;
                end else begin
                  state <= ST_FINISH;
                end
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_DRAW: begin
          cnt <= cnt + 3'd1;
          // Advance the cursor after the spacer column and wrap at the edge
          if (cnt == 3'(CELL_COLS - 1)) begin
            if (col_adv >= 9'(WIDTH_COLS)) begin
              cursor_col  <= '0;
              cursor_page <= cursor_page + PG_W'(1);
            end else begin
              cursor_col <= COL_W'(col_adv);
            end
            state <= ST_FINISH;
          end
        end
        ST_PIX_RD: begin
          state <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          state <= ST_FINISH;
        end
        ST_RD: begin
          state <= ST_RD_CAP;
        end
        ST_RD_CAP: begin
          rd_byte <= st_rdata;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign col_wide  = 16'(cursor_col);
  assign page_wide = 16'(cursor_page);

  // Output register: load when the finished request meets a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && rsp_free) begin
      rsp.read_data <= rd_byte;
      rsp.col_now   <= col_wide[6:0];
      rsp.page_now  <= page_wide[3:0];
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for text_pixel_framebuffer_writer
// Drives clear, cursor, character, pixel, read and spare-mode requests: first
// a directed table, then random traffic in three idling phases. An internal
// model of the frame store and text cursor predicts each response unless a
// fixed row types it in. Responses are checked field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_top;
  import tpfw_pkg::*;

  localparam int STORE_COLS  = 128;
  localparam int STORE_PAGES = 8;
  localparam int TEXT_LINES  = 8;
  localparam int LINE_CHARS  = 21;
  localparam int RANDOM_REQS = 1325;
  localparam int QUIET_LIMIT = 8000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 100;

  // Modes the block leaves alone
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // 5x7 font, codes 32..127, first column in the top byte
  localparam logic [39:0] GLYPH_FONT [0:95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
  };

  typedef struct {
    tpfw_req_t r;
    bit        fixed;
    tpfw_rsp_t rsp;
  } dir_step_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  tpfw_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  tpfw_rsp_t rsp;

  // Model of the frame store and text cursor
  logic [7:0]  page_bytes [0:STORE_PAGES*STORE_COLS-1];
  int unsigned cursor_x;
  int unsigned cursor_pg;

  tpfw_rsp_t   pending_rsp [$];
  dir_step_t   dir_tbl [$];
  int unsigned err_count = 0;
  int unsigned rsp_count = 0;
  int unsigned mode_seen [0:7];
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned idle_phase = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 1'b0;

  text_pixel_framebuffer_writer #(
    .WIDTH_COLS    (STORE_COLS),
    .PAGE_COUNT    (STORE_PAGES),
    .TEXT_LINES    (TEXT_LINES),
    .CHARS_PER_LINE(LINE_CHARS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic tpfw_req_t make_req(logic [2:0] m, logic [7:0] code,
                                         logic [7:0] line, logic [7:0] ccol,
                                         logic [7:0] x, logic [7:0] y, logic on);
    tpfw_req_t r;
    r.mode     = m;
    r.ch_code  = code;
    r.row      = line;
    r.col_char = ccol;
    r.pixel_x  = x;
    r.pixel_y  = y;
    r.pixel_on = on;
    return r;
  endfunction

  function automatic tpfw_rsp_t make_rsp(logic [7:0] rd, logic [6:0] cx, logic [3:0] pg);
    tpfw_rsp_t o;
    o.read_data = rd;
    o.col_now   = cx;
    o.page_now  = pg;
    return o;
  endfunction

  // Apply one request to the store model; return the response it gives
  function automatic tpfw_rsp_t render_request(tpfw_req_t r);
    tpfw_rsp_t   o;
    int unsigned code;
    int unsigned line;
    int unsigned ccol;
    int unsigned addr;
    logic [39:0] glyph;
    logic [7:0]  mask;
    o = '0;
    case (r.mode)
      MODE_CLEAR: begin
        foreach (page_bytes[i]) page_bytes[i] = 8'h00;
        cursor_x  = 0;
        cursor_pg = 0;
      end
      MODE_CURSOR: begin
        line = (r.row >= TEXT_LINES) ? TEXT_LINES - 1 : int'(r.row);
        ccol = (r.col_char >= LINE_CHARS) ? LINE_CHARS - 1 : int'(r.col_char);
        cursor_pg = line;
        cursor_x  = ccol * CELL_COLS;
      end
      MODE_CHAR: begin
        // drop characters once the cursor has run off the last page
        if (cursor_pg < STORE_PAGES) begin
          code = int'(r.ch_code);
          if (code < FIRST_CODE || code > LAST_CODE) code = FIRST_CODE;
          glyph = GLYPH_FONT[code - FIRST_CODE];
          for (int c = 0; c < CELL_COLS; c++) begin
            if (cursor_x + c < STORE_COLS)
              page_bytes[cursor_pg*STORE_COLS + cursor_x + c] =
                (c < GLYPH_COLS) ? glyph[39 - 8*c -: 8] : 8'h00;
          end
          cursor_x += CELL_COLS;
          if (cursor_x >= STORE_COLS) begin
            cursor_x = 0;
            cursor_pg++;
          end
        end
      end
      MODE_PIXEL: begin
        if (r.pixel_x < STORE_COLS && r.pixel_y < 8*STORE_PAGES) begin
          addr = (r.pixel_y >> 3) * STORE_COLS + r.pixel_x;
          mask = 8'h01 << r.pixel_y[2:0];
          if (r.pixel_on) page_bytes[addr] = page_bytes[addr] | mask;
          else            page_bytes[addr] = page_bytes[addr] & ~mask;
        end
      end
      MODE_READ: begin
        if (r.row < STORE_PAGES && r.pixel_x < STORE_COLS)
          o.read_data = page_bytes[r.row*STORE_COLS + r.pixel_x];
      end
      default: begin
      end
    endcase
    o.col_now  = cursor_x[6:0];
    o.page_now = cursor_pg[3:0];
    return o;
  endfunction

  // Mostly well-formed requests, with random noise in the unused fields
  function automatic tpfw_req_t random_request();
    tpfw_req_t   r;
    int unsigned pick;
    bit          wild;
    r.mode     = MODE_CLEAR;
    r.ch_code  = 8'($urandom);
    r.row      = 8'($urandom);
    r.col_char = 8'($urandom);
    r.pixel_x  = 8'($urandom);
    r.pixel_y  = 8'($urandom);
    r.pixel_on = 1'($urandom);
    pick = $urandom_range(999);
    wild = ($urandom_range(9) == 0);
    if (pick < 8) begin
      r.mode = MODE_CLEAR;
    end else if (pick < 130) begin
      r.mode = MODE_CURSOR;
      if (!wild) begin
        r.row      = 8'($urandom_range(TEXT_LINES - 1));
        r.col_char = ($urandom_range(2) == 0)
                     ? 8'($urandom_range(LINE_CHARS - 4, LINE_CHARS - 1))
                     : 8'($urandom_range(LINE_CHARS - 1));
      end
    end else if (pick < 520) begin
      r.mode = MODE_CHAR;
      if (!wild) r.ch_code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
    end else if (pick < 720) begin
      r.mode = MODE_PIXEL;
      if (!wild) begin
        r.pixel_x = 8'($urandom_range(STORE_COLS - 1));
        r.pixel_y = 8'($urandom_range(8*STORE_PAGES - 1));
      end
    end else if (pick < 970) begin
      r.mode = MODE_READ;
      if (!wild) begin
        r.row     = 8'($urandom_range(STORE_PAGES - 1));
        r.pixel_x = 8'($urandom_range(STORE_COLS - 1));
      end
    end else begin
      r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end
    return r;
  endfunction

  // Offer one request, hold it until accepted, then queue its response
  task automatic send_request(tpfw_req_t r, bit fixed, tpfw_rsp_t fixed_rsp);
    tpfw_rsp_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = render_request(r);
    pending_rsp.push_back(fixed ? fixed_rsp : predicted);
    mode_seen[r.mode]++;
  endtask

  // Receiver: random stall, plus one long hold-off in the last phase
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (idle_phase == 2 && !pressure_done) begin
      rsp_stall     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    tpfw_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: response with none pending: %h", $time, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.read_data !== want.read_data) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: read_data expected %h actual %h",
                     $time, want.read_data, rsp.read_data);
        end
        if (rsp.col_now !== want.col_now) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: col_now expected %0d actual %0d",
                     $time, want.col_now, rsp.col_now);
        end
        if (rsp.page_now !== want.page_now) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: page_now expected %0d actual %0d",
                     $time, want.page_now, rsp.page_now);
        end
      end
    end
  end

  // Watchdog: abort when no request or response moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (page_bytes[i]) page_bytes[i] = 8'h00;
    foreach (mode_seen[i]) mode_seen[i] = 0;
    cursor_x  = 0;
    cursor_pg = 0;

    // Directed table; fixed rows carry the response typed in
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd0)});
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd0)});
    dir_tbl.push_back('{make_req(MODE_CURSOR, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd120, 4'd7)});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd65, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd126, 4'd7)});
    // clipped at the right edge, wraps past the last page
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd8)});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd8)});
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd7, 8'd0, 8'd120, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h7E, 7'd0, 4'd8)});
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd7, 8'd0, 8'd125, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd8)});
    dir_tbl.push_back('{make_req(MODE_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd0)});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd126, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd32, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd31, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_CHAR, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd6, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd127, 8'd63, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd128, 8'd0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd64, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd7, 8'd0, 8'd127, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd127, 8'd63, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_SPARE_LO, 8'd0, 8'd7, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_SPARE_HI, 8'd0, 8'd7, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{make_req(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd0)});
    dir_tbl.push_back('{make_req(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1,
                        make_rsp(8'h00, 7'd0, 4'd0)});

    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    sender_idle_pct = 26;
    rsp_stall_pct   = 82;
    foreach (dir_tbl[i]) send_request(dir_tbl[i].r, dir_tbl[i].fixed, dir_tbl[i].rsp);

    // Random traffic in three idling phases
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        idle_phase      = 1;
        sender_idle_pct = 82;
        rsp_stall_pct   = 26;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        idle_phase      = 2;
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
      end
      send_request(random_request(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    // Drain the pending responses, then watch for strays
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d clear, %0d cursor, %0d char, %0d pixel, %0d read,",
             rsp_count, mode_seen[MODE_CLEAR], mode_seen[MODE_CURSOR],
             mode_seen[MODE_CHAR], mode_seen[MODE_PIXEL], mode_seen[MODE_READ]);
    $display("  %0d spare-mode; three idling phases and one long receiver hold-off; %0d errors",
             mode_seen[MODE_SPARE_LO] + mode_seen[MODE_SPARE_LO + 3'd1] +
             mode_seen[MODE_SPARE_HI], err_count);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ text_pixel_framebuffer_writer.f @@
rtl/tpfw_pkg.sv
rtl/tpfw_store.sv
rtl/text_pixel_framebuffer_writer.sv
tb/sv/tb_top.sv
